FILE: hdl/llwrm_pkg.sv
// ----------------------------------------------------------------------------
// llwrm_pkg
// Shared constants, types and small tables for the log line window meter.
// ----------------------------------------------------------------------------
package llwrm_pkg;

  localparam int unsigned WINDOW_DEPTH = 1024;
  localparam int unsigned PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned TIME_CHARS   = 20;
  localparam int unsigned TIDX_W       = $clog2(TIME_CHARS + 1);
  localparam int unsigned SEC_W        = 38;
  localparam int unsigned STATUS_W     = 10;
  localparam int unsigned WIN_W        = 28;
  localparam int unsigned TOTAL_W      = 32;
  localparam int unsigned CALC_CYCLES  = 8;
  localparam int unsigned CALC_CNT_W   = $clog2(CALC_CYCLES);

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_SKIP  = 3'd1;
  localparam logic [2:0] PH_DIG0  = 3'd2;
  localparam logic [2:0] PH_DIG2  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_PUSH,
    ST_POP_RD,
    ST_POP_CHK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic take;
    logic push;
    logic pop;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic finish;
    logic pop_more;
  } dp_stat_t;

  function automatic logic [3:0] digit_of(input logic [7:0] b);
    logic [7:0] d;
    d = b - CH_ZERO;
    return (b >= CH_ZERO && b <= CH_NINE) ? d[3:0] : 4'd0;
  endfunction

  function automatic logic [23:0] month_code(input logic [3:0] k);
    case (k)
      4'd0:    return 24'h4A616E;
      4'd1:    return 24'h466562;
      4'd2:    return 24'h4D6172;
      4'd3:    return 24'h417072;
      4'd4:    return 24'h4D6179;
      4'd5:    return 24'h4A756E;
      4'd6:    return 24'h4A756C;
      4'd7:    return 24'h417567;
      4'd8:    return 24'h536570;
      4'd9:    return 24'h4F6374;
      4'd10:   return 24'h4E6F76;
      4'd11:   return 24'h446563;
      default: return 24'h000000;
    endcase
  endfunction

  // days from March 1 to the first of the shifted month
  function automatic logic [8:0] doy_of(input logic [3:0] mm);
    case (mm)
      4'd0:    return 9'd0;
      4'd1:    return 9'd31;
      4'd2:    return 9'd61;
      4'd3:    return 9'd92;
      4'd4:    return 9'd122;
      4'd5:    return 9'd153;
      4'd6:    return 9'd184;
      4'd7:    return 9'd214;
      4'd8:    return 9'd245;
      4'd9:    return 9'd275;
      4'd10:   return 9'd306;
      4'd11:   return 9'd337;
      default: return 9'd0;
    endcase
  endfunction

endpackage

FILE: hdl/log_line_window_rate_meter_core.sv
// ----------------------------------------------------------------------------
// log_line_window_rate_meter_core
// Parses log bytes, converts each line's timestamp and tracks a time window.
// ----------------------------------------------------------------------------
//  channel  | signals                                      | direction
//  input    | in_valid/in_stall, char_byte, end_of_stream  | in
//  result   | out_valid/out_stall, eight fields            | out
//  config   | cfg_wr_en, cfg_wr_data                       | in
//
// One byte per cycle while no line is closing. A line end runs the timestamp
// arithmetic and a push, then a read and a check per entry tested for a pop,
// and loads the result register. Reset clears all control state.
// A stalled result holds; bytes keep flowing until the next line end.
// ----------------------------------------------------------------------------
module log_line_window_rate_meter_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [llwrm_pkg::WIN_W-1:0]      cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       char_byte,
  input  logic                             end_of_stream,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [llwrm_pkg::SEC_W-1:0]      line_seconds,
  output logic [llwrm_pkg::STATUS_W-1:0]   status_code,
  output logic                             server_error,
  output logic [llwrm_pkg::TOTAL_W-1:0]    server_error_total,
  output logic [llwrm_pkg::CNT_W-1:0]      window_count,
  output logic [llwrm_pkg::CNT_W-1:0]      max_window_count,
  output logic                             bad_month,
  output logic                             fifo_overflow
);
  import llwrm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  llwrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  llwrm_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .char_byte          (char_byte),
    .end_of_stream      (end_of_stream),
    .cmd                (cmd),
    .stat               (stat),
    .line_seconds       (line_seconds),
    .status_code        (status_code),
    .server_error       (server_error),
    .server_error_total (server_error_total),
    .window_count       (window_count),
    .max_window_count   (max_window_count),
    .bad_month          (bad_month),
    .fifo_overflow      (fifo_overflow)
  );

  a_err_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> server_error == (status_code >= STATUS_W'(500) &&
                                   status_code <= STATUS_W'(599)))
    else $error("server_error disagrees with status_code");

  a_max_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> window_count <= max_window_count)
    else $error("window count above max");

  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> window_count != '0)
    else $error("empty window after push");

endmodule

FILE: hdl/llwrm_ctrl.sv
// ----------------------------------------------------------------------------
// llwrm_ctrl
// Sequencer: byte intake, timestamp settle, push, pop loop and result hold.
// ----------------------------------------------------------------------------
module llwrm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  llwrm_pkg::dp_stat_t stat,
  output llwrm_pkg::dp_cmd_t  cmd
);
  import llwrm_pkg::*;

  state_t                state, state_next;
  logic [CALC_CNT_W-1:0] calc_cnt, calc_cnt_next;
  logic                  out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      calc_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      calc_cnt  <= calc_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next    = state;
    calc_cnt_next = calc_cnt;
    case (state)
      ST_IDLE: begin
        calc_cnt_next = '0;
        if (in_valid && stat.finish) state_next = ST_CALC;
      end
      ST_CALC: begin
        calc_cnt_next = calc_cnt + 1'b1;
        if (calc_cnt == CALC_CNT_W'(CALC_CYCLES - 1)) state_next = ST_PUSH;
      end
      ST_PUSH:    state_next = ST_POP_RD;
      ST_POP_RD:  state_next = ST_POP_CHK;
      ST_POP_CHK: state_next = stat.pop_more ? ST_POP_RD : ST_EMIT;
      ST_EMIT: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_stall     = (state != ST_IDLE);
    cmd.take     = in_valid && (state == ST_IDLE);
    cmd.push     = (state == ST_PUSH);
    cmd.pop      = (state == ST_POP_CHK) && stat.pop_more;
    cmd.load_out = (state == ST_EMIT) && (!out_valid || !out_stall);
    out_valid_next = cmd.load_out || (out_valid && out_stall);
  end

endmodule

FILE: hdl/llwrm_dp.sv
// ----------------------------------------------------------------------------
// llwrm_dp
// Line parser, timestamp arithmetic, stamp store and result registers.
// ----------------------------------------------------------------------------
module llwrm_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [llwrm_pkg::WIN_W-1:0]      cfg_wr_data,
  input  logic [7:0]                       char_byte,
  input  logic                             end_of_stream,
  input  llwrm_pkg::dp_cmd_t               cmd,
  output llwrm_pkg::dp_stat_t              stat,
  output logic [llwrm_pkg::SEC_W-1:0]      line_seconds,
  output logic [llwrm_pkg::STATUS_W-1:0]   status_code,
  output logic                             server_error,
  output logic [llwrm_pkg::TOTAL_W-1:0]    server_error_total,
  output logic [llwrm_pkg::CNT_W-1:0]      window_count,
  output logic [llwrm_pkg::CNT_W-1:0]      max_window_count,
  output logic                             bad_month,
  output logic                             fifo_overflow
);
  import llwrm_pkg::*;

  logic [WIN_W-1:0]    window_seconds;
  logic                in_time_field, in_request_field, line_has_bytes;
  logic [2:0]          status_phase;
  logic [STATUS_W-1:0] status_accum;
  logic [TIDX_W-1:0]   time_char_index;
  logic [7:0]          time_chars [TIME_CHARS];

  logic [SEC_W-1:0]    stamp_mem [WINDOW_DEPTH];
  logic [SEC_W-1:0]    rd_data;
  logic [PTR_W-1:0]    head, tail;
  logic [CNT_W-1:0]    count, max_count;
  logic [TOTAL_W-1:0]  error_total;
  logic                overflow;

  logic [6:0]          c_day;
  logic [13:0]         c_year;
  logic [18:0]         c_hms;
  logic [3:0]          c_mon;
  logic                c_bad;
  logic [13:0]         c_yp;
  logic [3:0]          c_mm;
  logic [4:0]          c_era;
  logic [8:0]          c_yoe;
  logic [17:0]         c_doe;
  logic signed [23:0]  c_days;
  logic signed [41:0]  c_prod;
  logic [SEC_W-1:0]    stamp;

  logic                is_dig, is_end, err;
  logic [13:0]         accum_ext;
  logic [23:0]         mcode;
  logic [3:0]          mon_idx;
  logic                mon_bad;
  logic [3:0]          m1;
  logic [26:0]         era_prod;
  logic [13:0]         yoe_w;
  logic [20:0]         yoe_hund;
  logic [38:0]         diff;

  assign is_dig = (status_phase >= PH_DIG0);
  assign is_end = (char_byte == CH_LF) || (char_byte == CH_NUL);
  assign stat.finish = end_of_stream ? line_has_bytes : (!is_dig && is_end);
  assign err = (status_accum >= STATUS_W'(500)) && (status_accum <= STATUS_W'(599));
  assign accum_ext = 14'(status_accum) * 14'd10 + 14'(digit_of(char_byte));

  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= '0;
    end else if (cfg_wr_en) begin
      window_seconds <= cfg_wr_data;
    end
  end

  // line parser
  always_ff @(posedge clk) begin
    if (rst || cmd.load_out || (cmd.take && end_of_stream && !line_has_bytes)) begin
      in_time_field    <= 1'b0;
      in_request_field <= 1'b0;
      status_phase     <= PH_IDLE;
      status_accum     <= '0;
      time_char_index  <= '0;
      line_has_bytes   <= 1'b0;
    end else if (cmd.take && !end_of_stream) begin
      if (is_dig) begin
        status_accum   <= accum_ext[STATUS_W-1:0];
        status_phase   <= (status_phase >= PH_DIG2) ? PH_IDLE : status_phase + 3'd1;
        line_has_bytes <= 1'b1;
      end else if (!is_end) begin
        line_has_bytes <= 1'b1;
        if (char_byte == CH_LBRACK) begin
          in_time_field <= 1'b1;
        end else if (char_byte == CH_RBRACK) begin
          in_time_field <= 1'b0;
        end else if (char_byte == CH_QUOTE) begin
          in_request_field <= !in_request_field;
          if (in_request_field) status_phase <= PH_SKIP;
        end else begin
          if (in_time_field && time_char_index < TIDX_W'(TIME_CHARS)) begin
            time_char_index <= time_char_index + 1'b1;
          end
          if (status_phase == PH_SKIP) begin
            status_phase <= PH_DIG0;
            status_accum <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && !end_of_stream && !is_dig && !is_end && in_time_field &&
        char_byte != CH_LBRACK && char_byte != CH_RBRACK && char_byte != CH_QUOTE &&
        time_char_index < TIDX_W'(TIME_CHARS)) begin
      time_chars[time_char_index] <= char_byte;
    end
  end

  // month lookup
  always_comb begin
    mcode   = {time_chars[3], time_chars[4], time_chars[5]};
    mon_idx = 4'd0;
    mon_bad = 1'b1;
    for (int k = 11; k >= 0; k--) begin
      if (mcode == month_code(4'(k))) begin
        mon_idx = 4'(k);
        mon_bad = 1'b0;
      end
    end
  end

  assign m1       = c_mon + 4'd1;
  assign era_prod = 27'(c_yp) * 27'd5243;
  assign yoe_w    = c_yp - 14'(c_era) * 14'd400;
  assign yoe_hund = 21'(c_yoe) * 21'd41;

  // timestamp chain; settles while the byte side is stalled
  always_ff @(posedge clk) begin
    c_day  <= 7'(digit_of(time_chars[0])) * 7'd10 + 7'(digit_of(time_chars[1]));
    c_year <= 14'(digit_of(time_chars[7])) * 14'd1000
            + 14'(digit_of(time_chars[8])) * 14'd100
            + 14'(digit_of(time_chars[9])) * 14'd10
            + 14'(digit_of(time_chars[10]));
    c_hms  <= (19'(digit_of(time_chars[12])) * 19'd10 + 19'(digit_of(time_chars[13])))
              * 19'd3600
            + (19'(digit_of(time_chars[15])) * 19'd10 + 19'(digit_of(time_chars[16])))
              * 19'd60
            + 19'(digit_of(time_chars[18])) * 19'd10 + 19'(digit_of(time_chars[19]));
    c_mon  <= mon_idx;
    c_bad  <= mon_bad;
    c_yp   <= c_year + 14'd400 - ((m1 <= 4'd2) ? 14'd1 : 14'd0);
    c_mm   <= (m1 > 4'd2) ? m1 - 4'd3 : m1 + 4'd9;
    c_era  <= era_prod[25:21];
    c_yoe  <= yoe_w[8:0];
    c_doe  <= 18'(c_yoe) * 18'd365 + 18'(c_yoe[8:2]) - 18'(yoe_hund[20:12])
            + 18'(doy_of(c_mm));
    c_days <= $signed(24'(c_era) * 24'd146097 + 24'(c_doe) + 24'(c_day))
            - 24'sd865566;
    c_prod <= {{18{c_days[23]}}, c_days} * 42'sd86400 + $signed({23'd0, c_hms});
    if (c_prod[41]) begin
      stamp <= '0;
    end else if (c_prod[40:SEC_W] != '0) begin
      stamp <= '1;
    end else begin
      stamp <= c_prod[SEC_W-1:0];
    end
  end

  // stamp store
  always_ff @(posedge clk) begin
    if (cmd.push) stamp_mem[tail] <= stamp;
    rd_data <= stamp_mem[head];
  end

  assign diff = {1'b0, stamp} - {1'b0, rd_data};
  assign stat.pop_more = (count > CNT_W'(1)) && !diff[SEC_W]
                       && (diff[SEC_W-1:0] > SEC_W'(window_seconds));

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      max_count   <= '0;
      error_total <= '0;
      overflow    <= 1'b0;
    end else if (cmd.push) begin
      overflow <= (count >= CNT_W'(WINDOW_DEPTH));
      if (count >= CNT_W'(WINDOW_DEPTH)) begin
        head <= (head == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : head + 1'b1;
      end else begin
        count <= count + 1'b1;
      end
      tail <= (tail == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : tail + 1'b1;
      if (err && error_total != '1) error_total <= error_total + 1'b1;
    end else if (cmd.pop) begin
      head  <= (head == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : head + 1'b1;
      count <= count - 1'b1;
    end else if (cmd.load_out && count > max_count) begin
      max_count <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      line_seconds       <= stamp;
      status_code        <= status_accum;
      server_error       <= err;
      server_error_total <= error_total;
      window_count       <= count;
      max_window_count   <= (count > max_count) ? count : max_count;
      bad_month          <= c_bad;
      fifo_overflow      <= overflow;
    end
  end

endmodule

FILE: tb/tb_log_line_window_rate_meter_core.sv
// ----------------------------------------------------------------------------
// tb_log_line_window_rate_meter_core
// Feeds log text byte by byte into the window rate meter. A model of the line
// parser, timestamp conversion and window store inside the bench works out
// each line result, which is compared field by field with the block output.
// ----------------------------------------------------------------------------
module tb_log_line_window_rate_meter_core;
  import llwrm_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       eos;
  } log_byte_t;

  typedef struct {
    logic [SEC_W-1:0]    sec;
    logic [STATUS_W-1:0] status;
    logic                err;
    logic [TOTAL_W-1:0]  total;
    logic [CNT_W-1:0]    wcount;
    logic [CNT_W-1:0]    wmax;
    logic                badmon;
    logic                ovf;
  } line_result_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  logic [WIN_W-1:0] cfg_wr_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [7:0] char_byte = '0;
  logic end_of_stream = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [SEC_W-1:0] line_seconds;
  logic [STATUS_W-1:0] status_code;
  logic server_error;
  logic [TOTAL_W-1:0] server_error_total;
  logic [CNT_W-1:0] window_count;
  logic [CNT_W-1:0] max_window_count;
  logic bad_month;
  logic fifo_overflow;

  log_line_window_rate_meter_core uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .char_byte(char_byte),
    .end_of_stream(end_of_stream), .out_valid(out_valid), .out_stall(out_stall),
    .line_seconds(line_seconds), .status_code(status_code),
    .server_error(server_error), .server_error_total(server_error_total),
    .window_count(window_count), .max_window_count(max_window_count),
    .bad_month(bad_month), .fifo_overflow(fifo_overflow)
  );

  always #5 clk = ~clk;

  log_byte_t    pending_bytes[$];
  line_result_t expected_lines[$];
  int errors = 0;
  int accepted = 0;
  int idle_cycles = 0;
  bit offered = 0;
  int send_idle = 31;
  int recv_idle = 60;
  int hold_left = 0;
  bit hold_done = 0;

  string mon_names[12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                           "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};

  // line parser and window state
  logic [WIN_W-1:0] win_len = '0;
  bit in_time, in_req, has_bytes;
  int unsigned st_phase, st_acc, tidx;
  logic [7:0] tchars[TIME_CHARS];
  longint stamps[WINDOW_DEPTH];
  int unsigned head, tail, fcount, fmax;
  logic [TOTAL_W-1:0] err_total;

  function automatic longint dig(logic [7:0] b);
    return (b >= "0" && b <= "9") ? longint'(b - "0") : 0;
  endfunction

  function automatic longint days_from_epoch(longint y, longint m);
    longint era, yoe, doy, doe;
    if (m <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic int unsigned nxt(int unsigned i);
    return (i + 1 >= WINDOW_DEPTH) ? 0 : i + 1;
  endfunction

  task automatic clear_line();
    in_time = 0; in_req = 0; st_phase = 0; st_acc = 0; tidx = 0; has_bytes = 0;
  endtask

  task automatic close_line();
    line_result_t r;
    longint mon, secs, stamp;
    bit bad;
    mon = 0;
    bad = 1;
    for (int k = 0; k < 12; k++) begin
      if (bad && tchars[3] == mon_names[k][0] && tchars[4] == mon_names[k][1] &&
          tchars[5] == mon_names[k][2]) begin
        mon = k;
        bad = 0;
      end
    end
    secs = (days_from_epoch(dig(tchars[7]) * 1000 + dig(tchars[8]) * 100 +
                            dig(tchars[9]) * 10 + dig(tchars[10]), mon + 1) +
            dig(tchars[0]) * 10 + dig(tchars[1]) - 1) * 86400 +
           (dig(tchars[12]) * 10 + dig(tchars[13])) * 3600 +
           (dig(tchars[15]) * 10 + dig(tchars[16])) * 60 +
           dig(tchars[18]) * 10 + dig(tchars[19]);
    if (secs < 0) stamp = 0;
    else if (secs > (64'd1 << SEC_W) - 1) stamp = (64'd1 << SEC_W) - 1;
    else stamp = secs;
    r.err = (st_acc >= 500 && st_acc <= 599);
    if (r.err && err_total != '1) err_total++;
    r.ovf = 0;
    if (fcount >= WINDOW_DEPTH) begin
      head = nxt(head);
      fcount--;
      r.ovf = 1;
    end
    stamps[tail] = stamp;
    tail = nxt(tail);
    fcount++;
    while (fcount > 1 && stamp - stamps[head] > longint'(win_len)) begin
      head = nxt(head);
      fcount--;
    end
    if (fcount > fmax) fmax = fcount;
    r.sec = SEC_W'(stamp);
    r.status = STATUS_W'(st_acc);
    r.total = err_total;
    r.wcount = CNT_W'(fcount);
    r.wmax = CNT_W'(fmax);
    r.badmon = bad;
    expected_lines.push_back(r);
    clear_line();
  endtask

  task automatic parse_byte(logic [7:0] c, logic eos);
    if (eos) begin
      if (has_bytes) close_line();
      else clear_line();
    end else if (st_phase >= 2) begin
      st_acc = 32'((st_acc * 10 + dig(c)) & 10'h3FF);
      st_phase = (st_phase >= 4) ? 0 : st_phase + 1;
      has_bytes = 1;
    end else if (c == CH_LF || c == CH_NUL) begin
      close_line();
    end else begin
      has_bytes = 1;
      if (c == CH_LBRACK) in_time = 1;
      else if (c == CH_RBRACK) in_time = 0;
      else if (c == CH_QUOTE) begin
        in_req = !in_req;
        if (!in_req) st_phase = 1;
      end else begin
        if (in_time && tidx < TIME_CHARS) begin
          tchars[tidx] = c;
          tidx++;
        end
        if (st_phase == 1) begin
          st_phase = 2;
          st_acc = 0;
        end
      end
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    line_result_t e;
    if (!rst) begin
      idle_cycles++;
      if (in_valid && !in_stall) begin
        parse_byte(char_byte, end_of_stream);
        accepted++;
        offered = 0;
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        if (expected_lines.size() == 0) begin
          $display("unexpected result transfer");
          errors++;
        end else begin
          e = expected_lines.pop_front();
          if (line_seconds !== e.sec) report("line_seconds", line_seconds, e.sec);
          if (status_code !== e.status) report("status_code", status_code, e.status);
          if (server_error !== e.err) report("server_error", server_error, e.err);
          if (server_error_total !== e.total)
            report("server_error_total", server_error_total, e.total);
          if (window_count !== e.wcount) report("window_count", window_count, e.wcount);
          if (max_window_count !== e.wmax)
            report("max_window_count", max_window_count, e.wmax);
          if (bad_month !== e.badmon) report("bad_month", bad_month, e.badmon);
          if (fifo_overflow !== e.ovf) report("fifo_overflow", fifo_overflow, e.ovf);
        end
      end
      if (idle_cycles > 30000) begin
        $display("watchdog: no transfer");
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (accepted > 1300) begin
        send_idle = 0; recv_idle = 0;
      end else if (accepted > 650) begin
        send_idle = 60; recv_idle = 31;
      end
      if (!hold_done && accepted > 1500) begin
        hold_done = 1;
        hold_left = 400;
      end
      if (!offered) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle) begin
          char_byte <= pending_bytes[0].b;
          end_of_stream <= pending_bytes[0].eos;
          void'(pending_bytes.pop_front());
          in_valid <= 1;
          offered = 1;
        end else begin
          in_valid <= 0;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  task automatic put_text(string s);
    log_byte_t x;
    for (int i = 0; i < s.len(); i++) begin
      x.b = s[i];
      x.eos = 0;
      pending_bytes.push_back(x);
    end
  endtask

  task automatic put_eos();
    log_byte_t x;
    x.b = 8'($urandom_range(255));
    x.eos = 1;
    pending_bytes.push_back(x);
  endtask

  // ending: 0 LF, 1 NUL, 2 end of stream
  task automatic put_line(int d, string mon, int y, int h, int m, int s, int st, int ending);
    log_byte_t x;
    put_text($sformatf("10.0.0.%0d - - ", $urandom_range(255)));
    put_text($sformatf("[%02d/%s/%04d:%02d:%02d:%02d +0000] ", d, mon, y, h, m, s));
    put_text($sformatf("\"GET /a HTTP/1.1\" %03d 512", st));
    if (ending == 0) begin
      put_text("\n");
    end else if (ending == 1) begin
      x.b = CH_NUL;
      x.eos = 0;
      pending_bytes.push_back(x);
    end else begin
      put_eos();
    end
  endtask

  task automatic random_line(ref longint t);
    string mon;
    int st;
    t += $urandom_range(40);
    mon = ($urandom_range(9) == 0) ? "Qux" : mon_names[$urandom_range(11)];
    st = ($urandom_range(2) == 0) ? $urandom_range(599, 500) : $urandom_range(999);
    put_line(int'(1 + (t / 86400) % 28), mon, 2000 + $urandom_range(30),
             int'((t / 3600) % 24), int'((t / 60) % 60), int'(t % 60), st,
             $urandom_range(2));
  endtask

  task automatic noise(int n);
    log_byte_t x;
    for (int i = 0; i < n; i++) begin
      x.b = 8'($urandom_range(255));
      x.eos = ($urandom_range(30) == 0);
      pending_bytes.push_back(x);
    end
  endtask

  task automatic drain();
    while (pending_bytes.size() > 0 || offered || expected_lines.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_window(logic [WIN_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 0;
    win_len = v;
  endtask

  initial begin
    longint t;
    clear_line();
    for (int i = 0; i < TIME_CHARS; i++) tchars[i] = 0;
    head = 0; tail = 0; fcount = 0; fmax = 0; err_total = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    set_window(0);
    put_line(10, "Oct", 2000, 13, 55, 36, 500, 0);
    put_line(99, "Feb", 9999, 99, 99, 99, 599, 1);
    put_line(0, "Zzz", 0, 0, 0, 0, 499, 2);
    put_line(31, "Dec", 1969, 23, 59, 59, 600, 0);
    put_eos();
    put_text("\n");
    put_text("x [01/Jan/1970:00:00:00] \"\"\" 50");
    put_eos();
    put_text("[01/Jan/1970:00:00:01] \"q\"[\"55\n\n");
    drain();

    set_window('1);
    t = 0;
    for (int i = 0; i < 3; i++) random_line(t);
    put_text({1030{"\n"}});
    drain();

    set_window(WIN_W'($urandom_range(200)));
    t = 0;
    for (int i = 0; i < 3; i++) begin
      random_line(t);
      noise($urandom_range(20));
    end
    drain();

    set_window(60);
    for (int i = 0; i < 3; i++) begin
      random_line(t);
      if ($urandom_range(2) == 0) begin
        put_text("y [05/Mar/2011:1");
        noise(6);
      end
    end
    drain();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
